/* src/wrpc_pkg.sv */
package wrpc_pkg;

    localparam int MAX_RAILS_DEF  = 4;
    localparam int MAX_WINDOW_DEF = 16;

    localparam logic [47:0] FULL48 = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] MODE_SINGLE = 3'd0;
    localparam logic [2:0] MODE_COUNT  = 3'd1;
    localparam logic [2:0] MODE_WSUM   = 3'd2;
    localparam logic [2:0] MODE_MAX    = 3'd3;
    localparam logic [2:0] MODE_MIN    = 3'd4;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_WINDOW = 3'd2;
    localparam logic [2:0] REG_OFFSET = 3'd3;
    localparam logic [2:0] REG_COEF0  = 3'd4;
    localparam logic [2:0] REG_COEF1  = 3'd5;
    localparam logic [2:0] REG_COEF2  = 3'd6;
    localparam logic [2:0] REG_COEF3  = 3'd7;

    localparam logic [31:0] COEF_RESET = 32'h0001_0000;

    // Signed saturating 64-bit add.
    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        begin
            s = a + b;
            if (!a[63] && !b[63] && s[63]) begin
                sat_add = 64'h7FFF_FFFF_FFFF_FFFF;
            end else if (a[63] && b[63] && !s[63]) begin
                sat_add = 64'h8000_0000_0000_0000;
            end else begin
                sat_add = s;
            end
        end
    endfunction

endpackage

/* src/wrpc_ram.sv */
module wrpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/windowed_rail_power_combiner.sv */
// Flow: each accepted sample is read from the history memories and checked; a warming or
// faulty rail goes straight to combining, any other through the divider and multiplier first.
// Throughput: one sample transaction at a time; the next is accepted once the previous is done,
// and a finished round also waits while the previous result transaction is still unaccepted.
// Reset: synchronous, active low; after reset a clearing pass over all MAX_RAILS*MAX_WINDOW
// entries zeroes the history memories, during which no sample is accepted.
module windowed_rail_power_combiner #(
    parameter int MAX_RAILS  = wrpc_pkg::MAX_RAILS_DEF,
    parameter int MAX_WINDOW = wrpc_pkg::MAX_WINDOW_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    // sample channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_rail_index,
    input  logic [63:0] i_energy_count,
    input  logic [63:0] i_time_stamp,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_combined_power,
    output logic        o_power_valid,
    output logic [2:0]  o_warming_rails,
    output logic [2:0]  o_faulty_rails
);
    import wrpc_pkg::*;

    localparam int DEPTH = MAX_RAILS * MAX_WINDOW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int RW    = (MAX_RAILS > 1) ? $clog2(MAX_RAILS) : 1;
    localparam int NW    = $clog2(MAX_RAILS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_DIV, ST_MUL, ST_COMBINE, ST_FINISH, ST_OUT
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [2:0]  r_rail_count;
    logic [4:0]  r_window;
    logic [47:0] r_offset;
    logic [31:0] r_coef [4];

    // Captured sample.
    logic [1:0]  r_rail;
    logic [63:0] r_energy;
    logic [63:0] r_time;
    logic [AW-1:0] r_addr;
    logic [SW-1:0] r_slot;

    logic [SW-1:0] r_oldest [MAX_RAILS];

    // Serial divider: 64 quotient bits then 16 fraction bits, one per cycle.
    logic [63:0] r_dt;
    logic [63:0] r_rem;
    logic [79:0] r_quo;    // dividend shifts out of the top, quotient in at bottom
    logic [6:0]  r_step;

    // Serial multiplier on the coefficient magnitude.
    logic [47:0] r_val;
    logic [31:0] r_mag;
    logic [79:0] r_prod;
    logic [79:0] r_mcand;
    logic        r_has;

    logic [63:0] r_acc;
    logic        r_seen;
    logic        r_poison;
    logic [2:0]  r_warm;
    logic [2:0]  r_fault;

    // Result registers; they hold while the result transaction waits.
    logic [47:0] r_out_power;
    logic        r_out_valid;
    logic [2:0]  r_out_warm;
    logic [2:0]  r_out_fault;

    // Memory ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [63:0]   mem_wdata_e;
    logic [63:0]   mem_wdata_t;
    logic [63:0]   old_e;
    logic [63:0]   old_t;

    // Clamped register values.
    logic [NW-1:0] n_rails;
    logic [WW-1:0] n_win;
    always_comb begin
        n_rails = (r_rail_count == 3'd0) ? NW'(1) :
                  ({29'd0, r_rail_count} > MAX_RAILS) ? NW'(MAX_RAILS) : NW'(r_rail_count);
        if (r_mode == MODE_SINGLE) begin
            n_rails = NW'(1);
        end
        n_win = (r_window == 5'd0) ? WW'(1) :
                ({27'd0, r_window} > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(r_window);
    end

    logic in_range;
    assign in_range = ({30'd0, i_rail_index} < 32'(n_rails));

    logic [AW-1:0] r_clr;

    wrpc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_e (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata_e),
        .i_raddr(r_addr), .o_rdata(old_e)
    );
    wrpc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_t (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata_t),
        .i_raddr(r_addr), .o_rdata(old_t)
    );

    logic st_check;
    logic warm_now, fault_now;
    assign st_check  = (r_state == ST_CHECK);
    assign warm_now  = (old_t == 64'd0);
    assign fault_now = !warm_now && ((r_time <= old_t) || (r_energy < old_e));

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata_e = r_energy;
        mem_wdata_t = r_time;
        if (r_state == ST_CLEAR) begin
            mem_we      = 1'b1;
            mem_waddr   = r_clr;
            mem_wdata_e = 64'd0;
            mem_wdata_t = 64'd0;
        end else if (st_check && !fault_now) begin
            mem_we = 1'b1;
        end
    end

    // Divider step.
    logic [64:0] div_try;
    logic [63:0] rem_sh;
    logic        rem_top;
    always_comb begin
        rem_top = r_rem[63];
        rem_sh  = {r_rem[62:0], r_quo[79]};
        div_try = {1'b0, rem_sh} - {1'b0, r_dt};
    end

    // Weighted term after the multiply.
    logic [63:0] term;
    logic [63:0] pmag;
    assign pmag = r_prod[79:16];
    assign term = r_coef[r_rail][31] ? (64'd0 - pmag) : pmag;

    logic signed [63:0] coef_s;
    assign coef_s = 64'(signed'(r_coef[r_rail]));

    // Final result.
    logic [63:0] fin_v;
    logic [63:0] fin_sum;
    assign fin_sum = r_acc[63] ? r_acc : sat_add(r_acc, 64'(signed'(r_offset)));
    assign fin_v   = fin_sum;

    logic [SW-1:0] slot_next;
    assign slot_next = (32'(r_slot) + 1 >= 32'(n_win)) ? SW'(0) : SW'(32'(r_slot) + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_mode       <= MODE_SINGLE;
            r_rail_count <= 3'd1;
            r_window     <= 5'd1;
            r_offset     <= '0;
            for (int k = 0; k < 4; k++) begin
                r_coef[k] <= COEF_RESET;
            end
            for (int k = 0; k < MAX_RAILS; k++) begin
                r_oldest[k] <= '0;
            end
            r_acc        <= '0;
            r_seen       <= 1'b0;
            r_poison     <= 1'b0;
            r_warm       <= '0;
            r_fault      <= '0;
            o_ready      <= 1'b0;
            o_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:   r_mode       <= i_cfg_data[2:0];
                    REG_COUNT:  r_rail_count <= i_cfg_data[2:0];
                    REG_WINDOW: r_window     <= i_cfg_data[4:0];
                    REG_OFFSET: r_offset     <= i_cfg_data;
                    REG_COEF0:  r_coef[0]    <= i_cfg_data[31:0];
                    REG_COEF1:  r_coef[1]    <= i_cfg_data[31:0];
                    REG_COEF2:  r_coef[2]    <= i_cfg_data[31:0];
                    REG_COEF3:  r_coef[3]    <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (32'(r_clr) == DEPTH - 1) begin
                        r_state <= ST_IDLE;
                        o_ready <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (i_valid && o_ready && in_range) begin
                        o_ready  <= 1'b0;
                        r_rail   <= i_rail_index;
                        r_energy <= i_energy_count;
                        r_time   <= i_time_stamp;
                        r_slot   <= (32'(r_oldest[RW'(i_rail_index)]) >= 32'(n_win)) ? SW'(0)
                                    : r_oldest[RW'(i_rail_index)];
                        r_addr   <= AW'(32'(i_rail_index) * MAX_WINDOW
                                    + ((32'(r_oldest[RW'(i_rail_index)]) >= 32'(n_win)) ? 0
                                    : 32'(r_oldest[RW'(i_rail_index)])));
                        if (i_rail_index == 2'd0) begin
                            r_acc    <= '0;
                            r_seen   <= 1'b0;
                            r_poison <= 1'b0;
                            r_warm   <= '0;
                            r_fault  <= '0;
                        end
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_has <= 1'b0;
                    if (warm_now) begin
                        if (r_warm != 3'd7) r_warm <= r_warm + 3'd1;
                        r_oldest[RW'(r_rail)] <= slot_next;
                        r_state <= ST_COMBINE;
                    end else if (fault_now) begin
                        if (r_fault != 3'd7) r_fault <= r_fault + 3'd1;
                        r_oldest[RW'(r_rail)] <= r_slot;
                        r_state <= ST_COMBINE;
                    end else begin
                        r_oldest[RW'(r_rail)] <= slot_next;
                        r_dt    <= r_time - old_t;
                        r_rem   <= '0;
                        r_quo   <= {r_energy - old_e, 16'd0};
                        r_step  <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (rem_top || !div_try[64]) begin
                        r_rem <= div_try[63:0];
                        r_quo <= {r_quo[78:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[78:0], 1'b0};
                    end
                    r_step <= r_step + 7'd1;
                    if (r_step == 7'd79) begin
                        r_state <= ST_MUL;
                        r_step  <= '0;
                    end
                end
                ST_MUL: begin
                    if (r_step == 7'd0) begin
                        // quotient integer part beyond 32 bits saturates
                        r_val   <= (r_quo[79:48] != 32'd0) ? FULL48 : r_quo[47:0];
                        r_has   <= 1'b1;
                        r_mag   <= r_coef[r_rail][31] ? (32'd0 - r_coef[r_rail])
                                                      : r_coef[r_rail];
                        r_mcand <= (r_quo[79:48] != 32'd0) ? {32'd0, FULL48}
                                                           : {32'd0, r_quo[47:0]};
                        r_prod  <= '0;
                        r_step  <= 7'd1;
                    end else begin
                        if (r_mag[0]) r_prod <= r_prod + r_mcand;
                        r_mag   <= {1'b0, r_mag[31:1]};
                        r_mcand <= {r_mcand[78:0], 1'b0};
                        r_step  <= r_step + 7'd1;
                        if (r_step == 7'd32) begin
                            r_step  <= '0;
                            r_state <= ST_COMBINE;
                        end
                    end
                end
                ST_COMBINE: begin
                    unique case (r_mode)
                        MODE_SINGLE: begin
                            r_acc    <= r_has ? {16'd0, r_val} : 64'd0;
                            r_poison <= !r_has;
                        end
                        MODE_COUNT: begin
                            if (r_has && ((coef_s < 0 && $signed({16'd0, r_val}) < -coef_s)
                                || (coef_s >= 0 && $signed({16'd0, r_val}) >= coef_s))) begin
                                r_acc <= sat_add(r_acc, 64'd65536);
                            end
                        end
                        MODE_WSUM: begin
                            if (r_has) r_acc <= sat_add(r_acc, term);
                            else       r_poison <= 1'b1;
                        end
                        MODE_MAX, MODE_MIN: begin
                            if (r_has && (!r_seen ||
                                (r_mode == MODE_MAX ? ($signed(term) > $signed(r_acc))
                                                    : ($signed(term) < $signed(r_acc))))) begin
                                r_acc  <= term;
                                r_seen <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (32'(r_rail) == 32'(n_rails) - 1) begin
                        r_state <= ST_FINISH;
                    end else begin
                        r_state <= ST_IDLE;
                        o_ready <= 1'b1;
                    end
                end
                ST_FINISH: begin
                    // The result registers are loaded only once the previous result
                    // transaction has been taken, so a waiting result never changes.
                    if (!o_valid) begin
                        if (r_mode == MODE_SINGLE) begin
                            r_out_valid <= !r_poison;
                            r_out_power <= r_poison ? 48'd0 : r_acc[47:0];
                        end else if ((r_mode == MODE_WSUM && r_poison)
                                     || (r_mode == MODE_MAX && !r_seen)) begin
                            r_out_valid <= 1'b0;
                            r_out_power <= 48'd0;
                        end else if (r_mode == MODE_MIN && !r_seen) begin
                            r_out_valid <= 1'b1;
                            r_out_power <= FULL48;
                        end else if (fin_v[63]) begin
                            r_out_valid <= 1'b0;
                            r_out_power <= 48'd0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_power <= (fin_v[62:48] != 15'd0) ? FULL48 : fin_v[47:0];
                        end
                        r_out_warm  <= r_warm;
                        r_out_fault <= r_fault;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_state <= ST_IDLE;
                        o_ready <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // Out-of-range rail indexes are consumed without effect.
            if (r_state == ST_IDLE && i_valid && o_ready && !in_range) begin
                o_ready <= 1'b1;
            end
        end
    end

    assign o_combined_power = r_out_power;
    assign o_power_valid    = r_out_valid;
    assign o_warming_rails  = r_out_warm;
    assign o_faulty_rails   = r_out_fault;

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");
    a_no_ready_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_ready)
        else $error("ready during clear");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_power_valid) |-> (o_combined_power == 48'd0))
        else $error("invalid result not zero");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_step < 7'd80))
        else $error("divider overrun");
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable({o_combined_power, o_power_valid,
                                                       o_warming_rails, o_faulty_rails})))
        else $error("waiting result changed");
`endif
endmodule
